[design/frx_pkg.sv]
// shared types, codes and the crc helper of the frame receiver
package frx_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOISE   = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_CRC     = 3'd3,
    ST_LINE    = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC    = 2'd0;
  localparam logic [1:0] CFG_KEY     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [7:0]  SYNC_RESET    = 8'hAA;
  localparam logic [7:0]  KEY_RESET     = 8'h5A;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  localparam logic [7:0]  CRC_POLY = 8'h8C;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [7:0]  xor_key;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // event from the parser to the emitter
  typedef struct packed {
    logic    post;
    logic    good;
    status_t status;
  } evt_t;

  // one result word as it sits in the output register
  typedef struct packed {
    status_t     status;
    logic        item_kind;
    logic [7:0]  message_id;
    logic [5:0]  payload_length;
    logic [4:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        last;
  } out_word_t;

  // reflected crc-8, lsb first, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] b;
    logic       mix;
    c = crc_in;
    b = data;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ b[0];
      c = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      b = {1'b0, b[7:1]};
    end
    return c;
  endfunction

endpackage

[design/xor_crc8_frame_receiver_unit.sv]
// top level of the xor scrambled crc-8 frame receiver
// Receive deframer for frames of SYNC, LEN, MSG_ID, LEN-1 payload bytes and CRC, every
// byte after SYNC XOR-decoded with xor_key and checked against a reflected CRC-8
// (poly 0x8C, init 0) over the decoded LEN, ID and payload. Input words are either a
// received byte (mode 0) or a millisecond tick (mode 1). Every input word is processed in
// the cycle it is accepted; a fault or a timeout gives one status word, a good frame
// gives a header word followed by one word per payload byte. Payload bytes are kept in a
// MAX_BYTES deep ram and read back through its registered port after the crc byte: each
// payload word passes through E_READ (address) and then E_WAIT (data to the output
// register), so a good frame with payload holds stall high until its last payload word
// is loaded, longer under output stall. A single output register sits between the two
// channels; a new input word is taken only when that register is empty or hands its
// word on in the same cycle, so a stalled result word also holds the input off.
module xor_crc8_frame_receiver_unit #(
  parameter int MAX_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  input  logic        line_error,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        item_kind,
  output logic [7:0]  message_id,
  output logic [5:0]  payload_length,
  output logic [4:0]  byte_index,
  output logic [7:0]  payload_byte,
  output logic        last
);

  localparam int LW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  frx_pkg::cfg_t      cfg;
  frx_pkg::evt_t      evt;
  frx_pkg::out_word_t out_word;
  logic               ready_in;
  logic               accept;
  logic [7:0]         frame_id;
  logic [LW-1:0]      frame_length;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte     <= frx_pkg::SYNC_RESET;
      cfg.xor_key       <= frx_pkg::KEY_RESET;
      cfg.timeout_ticks <= frx_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        frx_pkg::CFG_SYNC:    cfg.sync_byte     <= cfg_data[7:0];
        frx_pkg::CFG_KEY:     cfg.xor_key       <= cfg_data[7:0];
        frx_pkg::CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input is held off while a payload run drains from the store or the output register is stalled
  assign in_stall = !ready_in;
  assign accept   = in_valid && ready_in;

  frx_parse #(
    .MAX_BYTES(MAX_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .mode        (mode),
    .rx_byte     (rx_byte),
    .line_error  (line_error),
    .cfg         (cfg),
    .evt         (evt),
    .frame_id    (frame_id),
    .frame_length(frame_length),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata)
  );

  // payload store
  frx_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  frx_emit #(
    .MAX_BYTES(MAX_BYTES)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt),
    .frame_id    (frame_id),
    .frame_length(frame_length),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .ready_in    (ready_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  assign status         = out_word.status;
  assign item_kind      = out_word.item_kind;
  assign message_id     = out_word.message_id;
  assign payload_length = out_word.payload_length;
  assign byte_index     = out_word.byte_index;
  assign payload_byte   = out_word.payload_byte;
  assign last           = out_word.last;

  // store is written only by an accepted byte word
  a_store_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (accept && !mode && !line_error))
    else $error("payload store written without an accepted byte");

  // a posted result reaches the output register on the next edge
  a_post_loads: assert property (@(posedge clk) disable iff (rst)
    evt.post |=> out_valid)
    else $error("posted result not presented");

  // a good frame with payload blocks input while the store drains
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    (evt.post && evt.good && frame_length != '0) |=> in_stall)
    else $error("input taken during payload readback");

  // results are only posted for accepted words
  a_post_accept: assert property (@(posedge clk) disable iff (rst)
    evt.post |-> accept)
    else $error("result posted without an accepted word");

endmodule

[design/frx_ram.sv]
// generic single write port ram with registered read
module frx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/frx_parse.sv]
// frame parser: phase tracking, xor decode, crc, timeout, payload store writes
module frx_parse #(
  parameter int MAX_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          mode,
  input  logic [7:0]                    rx_byte,
  input  logic                          line_error,
  input  frx_pkg::cfg_t                 cfg,
  output frx_pkg::evt_t                 evt,
  output logic [7:0]                    frame_id,
  output logic [$clog2(MAX_BYTES+1)-1:0] frame_length,
  output logic                          mem_we,
  output logic [(MAX_BYTES > 1 ? $clog2(MAX_BYTES) : 1)-1:0] mem_waddr,
  output logic [7:0]                    mem_wdata
);

  localparam int LW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [8:0] LEN_LIMIT = 9'(MAX_BYTES + 1);

  typedef enum logic [4:0] {
    PH_SYNC = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_ID   = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_CRC  = 5'b10000
  } phase_t;

  phase_t        phase, phase_next;
  logic [LW-1:0] frame_length_next;
  logic [7:0]    frame_id_next;
  logic [LW-1:0] byte_count, byte_count_next;
  logic [LW-1:0] count_inc;
  logic [7:0]    running_crc, running_crc_next;
  logic [15:0]   idle_ticks, idle_ticks_next;
  logic [15:0]   idle_sat;
  logic [7:0]    dec;
  logic [7:0]    crc_in;
  logic [7:0]    crc_out;
  logic          in_frame;

  assign dec       = rx_byte ^ cfg.xor_key;
  assign crc_in    = (phase == PH_LEN) ? 8'h00 : running_crc;
  assign crc_out   = frx_pkg::crc8_step(crc_in, dec);
  assign count_inc = byte_count + LW'(1);
  assign idle_sat  = (idle_ticks == frx_pkg::IDLE_MAX) ? idle_ticks : idle_ticks + 16'd1;
  assign in_frame  = (phase == PH_LEN) || (phase == PH_ID) || (phase == PH_PAY) ||
                     (phase == PH_CRC);

  assign mem_waddr = byte_count[AW-1:0];
  assign mem_wdata = dec;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    frame_id_next     = frame_id;
    byte_count_next   = byte_count;
    running_crc_next  = running_crc;
    idle_ticks_next   = idle_ticks;
    evt               = '{post: 1'b0, good: 1'b0, status: frx_pkg::ST_OK};
    mem_we            = 1'b0;
    if (accept) begin
      if (mode) begin
        // tick: count idle time only inside a frame
        if (in_frame) begin
          idle_ticks_next = idle_sat;
          if (idle_sat > cfg.timeout_ticks) begin
            evt.post   = 1'b1;
            evt.status = frx_pkg::ST_TIMEOUT;
            phase_next = PH_SYNC;
          end
        end
      end else begin
        idle_ticks_next = '0;
        if (line_error) begin
          evt.post   = 1'b1;
          evt.status = frx_pkg::ST_LINE;
          phase_next = PH_SYNC;
        end else begin
          unique case (phase)
            PH_LEN: begin
              if (dec == 8'd0 || {1'b0, dec} > LEN_LIMIT) begin
                evt.post   = 1'b1;
                evt.status = frx_pkg::ST_BAD_LEN;
                phase_next = PH_SYNC;
              end else begin
                frame_length_next = LW'(dec - 8'd1);
                running_crc_next  = crc_out;
                phase_next        = PH_ID;
              end
            end
            PH_ID: begin
              frame_id_next    = dec;
              running_crc_next = crc_out;
              byte_count_next  = '0;
              phase_next       = (frame_length == '0) ? PH_CRC : PH_PAY;
            end
            PH_PAY: begin
              mem_we           = 1'b1;
              running_crc_next = crc_out;
              byte_count_next  = count_inc;
              if (count_inc >= frame_length) begin
                phase_next = PH_CRC;
              end
            end
            PH_CRC: begin
              evt.post   = 1'b1;
              phase_next = PH_SYNC;
              if (dec != running_crc) begin
                evt.status = frx_pkg::ST_CRC;
              end else begin
                evt.good = 1'b1;
              end
            end
            default: begin
              // hunting for sync, raw byte compare
              if (rx_byte == cfg.sync_byte) begin
                phase_next       = PH_LEN;
                running_crc_next = 8'h00;
              end else begin
                evt.post   = 1'b1;
                evt.status = frx_pkg::ST_NOISE;
                phase_next = PH_SYNC;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC;
      frame_length <= '0;
      frame_id     <= '0;
      byte_count   <= '0;
      running_crc  <= '0;
      idle_ticks   <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      frame_id     <= frame_id_next;
      byte_count   <= byte_count_next;
      running_crc  <= running_crc_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

endmodule

[design/frx_emit.sv]
// result sequencer: output register and payload readback from the store
module frx_emit #(
  parameter int MAX_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  frx_pkg::evt_t                 evt,
  input  logic [7:0]                    frame_id,
  input  logic [$clog2(MAX_BYTES+1)-1:0] frame_length,
  output logic [(MAX_BYTES > 1 ? $clog2(MAX_BYTES) : 1)-1:0] mem_raddr,
  input  logic [7:0]                    mem_rdata,
  output logic                          ready_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output frx_pkg::out_word_t            out_word
);

  localparam int LW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_READ = 3'b010,
    E_WAIT = 3'b100
  } emit_state_t;

  emit_state_t        state, state_next;
  logic [AW-1:0]      idx, idx_next;
  logic               slot_free;
  logic               load;
  logic               is_last;
  frx_pkg::out_word_t word_next;

  assign slot_free = !out_valid || !out_stall;
  assign ready_in  = (state == E_IDLE) && slot_free;
  assign mem_raddr = idx;
  assign is_last   = (LW'(idx) + LW'(1)) == frame_length;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    word_next  = '{status: frx_pkg::ST_OK, item_kind: 1'b0, message_id: 8'h00,
                   payload_length: 6'd0, byte_index: 5'd0, payload_byte: 8'h00,
                   last: 1'b1};
    unique case (state)
      E_IDLE: begin
        if (evt.post) begin
          load = 1'b1;
          if (evt.good) begin
            word_next.message_id     = frame_id;
            word_next.payload_length = 6'(frame_length);
            word_next.last           = (frame_length == '0);
            if (frame_length != '0) begin
              idx_next   = '0;
              state_next = E_READ;
            end
          end else begin
            word_next.status = evt.status;
          end
        end
      end
      E_READ: begin
        state_next = E_WAIT;
      end
      E_WAIT: begin
        if (slot_free) begin
          load                     = 1'b1;
          word_next.item_kind      = 1'b1;
          word_next.message_id     = frame_id;
          word_next.payload_length = 6'(frame_length);
          word_next.byte_index     = 5'(idx);
          word_next.payload_byte   = mem_rdata;
          word_next.last           = is_last;
          if (is_last) begin
            state_next = E_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = E_READ;
          end
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word_next;
    end
  end

endmodule

[tb/sv/tb.sv]
// self-checking testbench of the xor scrambled crc-8 frame receiver
module tb;
  import frx_pkg::*;

  localparam int MAX_BYTES     = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PLAN_ROWS     = 31;
  localparam int BURST_TICKS   = 4;

  // receive phases of the frame parser
  typedef enum logic [2:0] {
    HUNT,
    GET_LEN,
    GET_ID,
    GET_PAYLOAD,
    GET_CRC
  } rx_phase_e;

  // kinds of row in the directed table
  typedef enum logic [2:0] {
    K_BYTE,     // one received byte
    K_TICK,     // one millisecond tick
    K_TICKS,    // a burst of ticks, arg gives the count
    K_CRC_OK,   // the right crc byte for the frame so far
    K_CRC_BAD,  // the right crc byte with one bit flipped
    K_CFG       // register write once the block is quiet
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] raw;
    logic       lerr;
    int         arg;
    logic [1:0] reg_sel;
    logic       fixed;     // expected words typed in below, not predicted
    logic       one_word;  // fixed row gives one status word, else none
    status_t    st;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_SYNC;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        line_error = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        item_kind;
  logic [7:0]  message_id;
  logic [5:0]  payload_length;
  logic [4:0]  byte_index;
  logic [7:0]  payload_byte;
  logic        last;

  xor_crc8_frame_receiver_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .rx_byte        (rx_byte),
    .line_error     (line_error),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .item_kind      (item_kind),
    .message_id     (message_id),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .last           (last)
  );

  always #4 clk = ~clk;

  // deframer model state, kept in step with every accepted word
  rx_phase_e   rx_phase;
  logic [5:0]  frame_len;
  logic [7:0]  frame_id;
  logic [5:0]  byte_cnt;
  logic [7:0]  payload_mem [MAX_BYTES];
  logic [7:0]  crc_acc;
  logic [15:0] idle_count;
  logic [7:0]  sync_val;
  logic [7:0]  xor_key;
  logic [15:0] timeout_limit;

  out_word_t   fresh_words [$];     // words caused by the last accepted input word
  out_word_t   expected_words [$];  // words still owed by the block, oldest first
  int          words_fed = 0;
  int          results_due = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  // directed table, started under the reset register values
  // kind, raw, lerr, arg, reg_sel, fixed, one_word, st
  plan_row_t plan [PLAN_ROWS] = '{
    // noise and line error while hunting, tick while hunting is dropped
    '{K_BYTE,    8'h00, 1'b0, 0, CFG_SYNC, 1'b1, 1'b1, ST_NOISE},
    '{K_BYTE,    8'hFF, 1'b1, 0, CFG_SYNC, 1'b1, 1'b1, ST_LINE},
    '{K_TICK,    8'h00, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    // length zero, then length 34, both rejected
    '{K_BYTE,    8'hAA, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'h5A, 1'b0, 0, CFG_SYNC, 1'b1, 1'b1, ST_BAD_LEN},
    '{K_BYTE,    8'hAA, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'h78, 1'b0, 0, CFG_SYNC, 1'b1, 1'b1, ST_BAD_LEN},
    // good frame with empty payload
    '{K_BYTE,    8'hAA, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'h5B, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'hFF, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_CRC_OK,  8'h00, 1'b0, 0, CFG_SYNC, 1'b0, 1'b0, ST_OK},
    // good frame, two payload bytes, sync value used as the id
    '{K_BYTE,    8'hAA, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'h59, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'hAA, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'h00, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'hFF, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_CRC_OK,  8'h00, 1'b0, 0, CFG_SYNC, 1'b0, 1'b0, ST_OK},
    // crc mismatch
    '{K_BYTE,    8'hAA, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'h5B, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'h00, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_CRC_BAD, 8'h00, 1'b0, 0, CFG_SYNC, 1'b1, 1'b1, ST_CRC},
    // one tick allowed, a byte clears the idle count, two ticks time out
    '{K_CFG,     8'h00, 1'b0, 1, CFG_TIMEOUT, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'hAA, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_TICK,    8'h00, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'h5B, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_TICK,    8'h00, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_TICK,    8'h00, 1'b0, 0, CFG_SYNC, 1'b1, 1'b1, ST_TIMEOUT},
    // largest limit: a few ticks inside a frame do not time out
    '{K_CFG,     8'h00, 1'b0, 65535, CFG_TIMEOUT, 1'b1, 1'b0, ST_OK},
    '{K_BYTE,    8'hAA, 1'b0, 0, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    '{K_TICKS,   8'h00, 1'b0, BURST_TICKS, CFG_SYNC, 1'b1, 1'b0, ST_OK},
    // line error in the middle of a frame
    '{K_BYTE,    8'h5B, 1'b1, 0, CFG_SYNC, 1'b1, 1'b1, ST_LINE}
  };

  // reflected crc-8 over one byte, lsb first
  function automatic logic [7:0] crc8_reflected(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] b;
    c = acc;
    b = data;
    repeat (8) begin
      if (c[0] ^ b[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

  // fault word: only status and last are set
  function automatic out_word_t status_word(input status_t st);
    out_word_t w;
    w = '0;
    w.status = st;
    w.last = 1'b1;
    return w;
  endfunction

  // advance the model by one accepted word, leave its results in fresh_words
  task automatic deframe_predict(input logic m, input logic [7:0] raw, input logic lerr);
    logic [7:0] d;
    out_word_t  w;
    fresh_words.delete();
    d = raw ^ xor_key;
    if (m) begin
      // ticks only count inside a frame
      if (rx_phase != HUNT) begin
        if (idle_count != IDLE_MAX) begin
          idle_count = idle_count + 16'd1;
        end
        if (idle_count > timeout_limit) begin
          fresh_words.push_back(status_word(ST_TIMEOUT));
          rx_phase = HUNT;
        end
      end
    end else begin
      idle_count = '0;
      if (lerr) begin
        fresh_words.push_back(status_word(ST_LINE));
        rx_phase = HUNT;
      end else begin
        case (rx_phase)
          HUNT: begin
            // the raw byte is compared, not the decoded one
            if (raw == sync_val) begin
              rx_phase = GET_LEN;
              crc_acc = '0;
            end else begin
              fresh_words.push_back(status_word(ST_NOISE));
            end
          end
          GET_LEN: begin
            if (d == 8'd0 || d > MAX_BYTES + 1) begin
              fresh_words.push_back(status_word(ST_BAD_LEN));
              rx_phase = HUNT;
            end else begin
              frame_len = 6'(d - 8'd1);
              crc_acc = crc8_reflected(8'h00, d);
              rx_phase = GET_ID;
            end
          end
          GET_ID: begin
            frame_id = d;
            crc_acc = crc8_reflected(crc_acc, d);
            byte_cnt = '0;
            rx_phase = (frame_len == 0) ? GET_CRC : GET_PAYLOAD;
          end
          GET_PAYLOAD: begin
            payload_mem[byte_cnt] = d;
            crc_acc = crc8_reflected(crc_acc, d);
            byte_cnt = byte_cnt + 6'd1;
            if (byte_cnt >= frame_len) begin
              rx_phase = GET_CRC;
            end
          end
          default: begin
            rx_phase = HUNT;
            if (d != crc_acc) begin
              fresh_words.push_back(status_word(ST_CRC));
            end else begin
              // header, then the stored payload as one run
              w = '0;
              w.status = ST_OK;
              w.message_id = frame_id;
              w.payload_length = frame_len;
              w.last = (frame_len == 0);
              fresh_words.push_back(w);
              for (int i = 0; i < frame_len; i++) begin
                w.item_kind = 1'b1;
                w.byte_index = 5'(i);
                w.payload_byte = payload_mem[i];
                w.last = (i + 1 == frame_len);
                fresh_words.push_back(w);
              end
            end
          end
        endcase
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // hold one word on the input channel until it is taken
  task automatic drive_word(input logic m, input logic [7:0] raw, input logic lerr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= raw;
    line_error <= lerr;
    do @(posedge clk); while (in_stall);
    // ticks while hunting are dropped by the block and not counted
    if (!(m && rx_phase == HUNT)) begin
      words_fed++;
    end
  endtask

  task automatic send_word(input logic m, input logic [7:0] raw, input logic lerr);
    drive_word(m, raw, lerr);
    deframe_predict(m, raw, lerr);
    foreach (fresh_words[k]) begin
      expected_words.push_back(fresh_words[k]);
    end
    results_due += fresh_words.size();
  endtask

  task automatic tick();
    send_word(1'b1, 8'($urandom), 1'($urandom_range(1)));
  endtask

  // frame byte with a rare line error
  task automatic frame_byte(input logic [7:0] raw);
    send_word(1'b0, raw, $urandom_range(99) < 3);
  endtask

  // a few ticks now and then inside a frame
  task automatic maybe_ticks();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 2)) tick();
    end
  endtask

  // wait until nothing is owed and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_write high, the caller lowers it after the last write
  task automatic write_reg(input logic [1:0] sel, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      CFG_SYNC:    sync_val = val[7:0];
      CFG_KEY:     xor_key = val[7:0];
      CFG_TIMEOUT: timeout_limit = val;
      default:     ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] s, input logic [7:0] k, input logic [15:0] t);
    write_reg(CFG_SYNC, {8'h00, s});
    write_reg(CFG_KEY, {8'h00, k});
    write_reg(CFG_TIMEOUT, t);
    cfg_write <= 1'b0;
  endtask

  // frame with random content and a usually right crc byte, len_d of zero picks a length
  task automatic send_frame(input int len_d);
    logic [7:0] good;
    if (len_d == 0) begin
      len_d = ($urandom_range(9) == 0) ? MAX_BYTES + 1 : $urandom_range(1, 9);
    end
    frame_byte(sync_val);
    maybe_ticks();
    frame_byte(8'(len_d) ^ xor_key);
    maybe_ticks();
    frame_byte(8'($urandom));
    for (int i = 1; i < len_d; i++) begin
      frame_byte(8'($urandom));
      maybe_ticks();
    end
    good = crc_acc ^ xor_key;
    if ($urandom_range(99) < 85) begin
      frame_byte(good);
    end else begin
      frame_byte(good ^ 8'($urandom_range(1, 255)));
    end
  endtask

  // idle pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both lightly
  task automatic set_idling(input int sel);
    case (sel)
      1:       begin send_idle_pct = 70; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 70; end
      3:       begin send_idle_pct = 24; stall_pct = 24; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // random stall on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // every accepted result word against the oldest expectation
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word status %0h kind %0h id %0h",
                                status, item_kind, message_id));
      end else begin
        want = expected_words.pop_front();
        check_field("status", 8'(status), 8'(want.status));
        check_field("item_kind", 8'(item_kind), 8'(want.item_kind));
        check_field("message_id", message_id, want.message_id);
        check_field("payload_length", 8'(payload_length), 8'(want.payload_length));
        check_field("byte_index", 8'(byte_index), 8'(want.byte_index));
        check_field("payload_byte", payload_byte, want.payload_byte);
        check_field("last", 8'(last), 8'(want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    plan_row_t  row;
    logic [7:0] raw;
    int         phase_start;
    int         len_d;

    // model after reset
    rx_phase = HUNT;
    frame_len = '0;
    frame_id = '0;
    byte_cnt = '0;
    crc_acc = '0;
    idle_count = '0;
    sync_val = SYNC_RESET;
    xor_key = KEY_RESET;
    timeout_limit = TIMEOUT_RESET;
    foreach (payload_mem[k]) begin
      payload_mem[k] = '0;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table, no idling
    set_idling(0);
    foreach (plan[r]) begin
      row = plan[r];
      case (row.kind)
        K_CFG: begin
          settle();
          write_reg(row.reg_sel, row.arg[15:0]);
          cfg_write <= 1'b0;
        end
        K_TICKS: begin
          repeat (row.arg) begin
            drive_word(1'b1, 8'h00, 1'b0);
            deframe_predict(1'b1, 8'h00, 1'b0);
          end
        end
        default: begin
          raw = row.raw;
          if (row.kind == K_CRC_OK) begin
            raw = crc_acc ^ xor_key;
          end else if (row.kind == K_CRC_BAD) begin
            raw = crc_acc ^ xor_key ^ 8'h01;
          end
          drive_word(row.kind == K_TICK, raw, row.lerr);
          deframe_predict(row.kind == K_TICK, raw, row.lerr);
          if (!row.fixed) begin
            foreach (fresh_words[k]) begin
              expected_words.push_back(fresh_words[k]);
            end
          end else if (row.one_word) begin
            expected_words.push_back(status_word(row.st));
          end
        end
      endcase
    end

    // random phases, each under its own register setting, each with an idle pattern
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: program_regs(SYNC_RESET, KEY_RESET, TIMEOUT_RESET);
        1: program_regs(8'h00, 8'hFF, 16'd0);
        2: program_regs(8'hFF, 8'h00, 16'd3);
        3: program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(1, 20)));
        4: program_regs(8'($urandom), 8'($urandom), 16'hFFFF);
        default: program_regs(8'($urandom), 8'($urandom), 16'($urandom));
      endcase
      set_idling((p == 4) ? 0 : (p == 5) ? $urandom_range(1, 3) : p);
      phase_start = words_fed;
      // longest payload up front in two phases
      if (p == 0 || p == 4) begin
        send_frame(MAX_BYTES + 1);
      end
      while (words_fed - phase_start < 8 || (p == 5 && results_due < 40)) begin
        if ($urandom_range(3) != 0) begin
          send_frame(0);
        end else begin
          case ($urandom_range(4))
            // stray byte, sometimes with a line error
            0: send_word(1'b0, 8'($urandom), $urandom_range(3) == 0);
            // ticks, mostly while hunting
            1: repeat ($urandom_range(1, 3)) tick();
            // length zero or too long
            2: begin
              send_word(1'b0, sync_val, 1'b0);
              send_word(1'b0, (($urandom_range(1) == 1) ? 8'd0 :
                               8'($urandom_range(MAX_BYTES + 2, 255))) ^ xor_key, 1'b0);
            end
            // frame left idle until it times out, where the limit is small
            3: begin
              send_word(1'b0, sync_val, 1'b0);
              if (timeout_limit <= 16'd64) begin
                repeat (int'(timeout_limit) + 1) tick();
              end else begin
                repeat (3) tick();
                send_word(1'b0, 8'($urandom), 1'b1);
              end
            end
            // frame cut short by a line error after the id
            default: begin
              len_d = $urandom_range(1, MAX_BYTES + 1);
              send_word(1'b0, sync_val, 1'b0);
              send_word(1'b0, 8'(len_d) ^ xor_key, 1'b0);
              send_word(1'b0, 8'($urandom), 1'b0);
              send_word(1'b0, 8'($urandom), 1'b1);
            end
          endcase
        end
      end
      // back to hunting before the registers change
      if (rx_phase != HUNT) begin
        send_word(1'b0, 8'($urandom), 1'b1);
      end
    end

    settle();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
